[hdl/rnve_pkg.sv]
// shared types, constants and numeral table for the roman numeral vinculum encoder
// used by rnve_ctrl, rnve_dpath, roman_numeral_vinculum_encoder_core and rnve_checker
package rnve_pkg;

   localparam int VALUE_W = 32;
   localparam int GLYPH_W = 3;
   localparam int BARS_W = 2;
   localparam int AMT_W = 13;
   localparam int CNT_W = 2;
   localparam int IDX_W = 4;
   localparam int WORTH_W = 10;
   localparam int ENTRIES = 13;
   localparam int MUL_A_W = 26;
   localparam int RECIP_W = 27;
   localparam int PROD_W = 53;
   localparam int DIVISOR_W = 20;
   localparam int MAX_GLYPHS = 39;
   localparam int GCNT_W = 6;

   localparam logic [GLYPH_W-1:0] GLYPH_I = 3'd0;
   localparam logic [GLYPH_W-1:0] GLYPH_V = 3'd1;
   localparam logic [GLYPH_W-1:0] GLYPH_X = 3'd2;
   localparam logic [GLYPH_W-1:0] GLYPH_L = 3'd3;
   localparam logic [GLYPH_W-1:0] GLYPH_C = 3'd4;
   localparam logic [GLYPH_W-1:0] GLYPH_D = 3'd5;
   localparam logic [GLYPH_W-1:0] GLYPH_M = 3'd6;
   localparam logic [GLYPH_W-1:0] GLYPH_NONE = 3'd7;

   localparam logic [BARS_W-1:0] BARS_NONE = 2'd0;
   localparam logic [BARS_W-1:0] BARS_KILO = 2'd1;
   localparam logic [BARS_W-1:0] BARS_MEGA = 2'd2;
   localparam logic [BARS_W-1:0] BARS_BAD = 2'd3;

   localparam logic [VALUE_W-1:0] LIMIT_MEGA = 32'd4000000;
   localparam logic [VALUE_W-1:0] LIMIT_KILO = 32'd4000;
   // reciprocals of 15625 (shift 40) and 125 (shift 26), exact for the operand ranges
   localparam logic [RECIP_W-1:0] RECIP_MEGA = 27'd70368745;
   localparam logic [RECIP_W-1:0] RECIP_KILO = 27'd536871;
   localparam logic [DIVISOR_W-1:0] DIVISOR_MEGA = 20'd1000000;
   localparam logic [DIVISOR_W-1:0] DIVISOR_KILO = 20'd1000;
   // divider phases, counted down
   localparam logic [CNT_W-1:0] DIV_PH_MUL = 2'd2;
   localparam logic [CNT_W-1:0] DIV_PH_BACK = 2'd1;
   localparam logic [CNT_W-1:0] DIV_PH_SUB = 2'd0;
   localparam logic [GCNT_W-1:0] GLYPH_LAST_IDX = GCNT_W'(MAX_GLYPHS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_MEGA,
      S_CHK_KILO,
      S_DIV,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_mega;
      logic start_kilo;
      logic load_plain;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic mega_big;
      logic kilo_big;
      logic rem_zero;
      logic div_last;
      logic out_free;
      logic part_done;
      logic glyph_cap;
   } status_type;

   function automatic logic [WORTH_W-1:0] entry_worth(input logic [IDX_W-1:0] idx);
      logic [WORTH_W-1:0] w;
      case (idx)
         4'd0: w = 10'd1000;
         4'd1: w = 10'd900;
         4'd2: w = 10'd500;
         4'd3: w = 10'd400;
         4'd4: w = 10'd100;
         4'd5: w = 10'd90;
         4'd6: w = 10'd50;
         4'd7: w = 10'd40;
         4'd8: w = 10'd10;
         4'd9: w = 10'd9;
         4'd10: w = 10'd5;
         4'd11: w = 10'd4;
         default: w = 10'd1;
      endcase
      return w;
   endfunction

   function automatic logic [GLYPH_W-1:0] entry_first(input logic [IDX_W-1:0] idx);
      logic [GLYPH_W-1:0] g;
      case (idx)
         4'd0: g = GLYPH_M;
         4'd1: g = GLYPH_C;
         4'd2: g = GLYPH_D;
         4'd3: g = GLYPH_C;
         4'd4: g = GLYPH_C;
         4'd5: g = GLYPH_X;
         4'd6: g = GLYPH_L;
         4'd7: g = GLYPH_X;
         4'd8: g = GLYPH_X;
         4'd9: g = GLYPH_I;
         4'd10: g = GLYPH_V;
         4'd11: g = GLYPH_I;
         default: g = GLYPH_I;
      endcase
      return g;
   endfunction

   function automatic logic [GLYPH_W-1:0] entry_second(input logic [IDX_W-1:0] idx);
      logic [GLYPH_W-1:0] g;
      case (idx)
         4'd1: g = GLYPH_M;
         4'd3: g = GLYPH_D;
         4'd5: g = GLYPH_C;
         4'd7: g = GLYPH_L;
         4'd9: g = GLYPH_X;
         4'd11: g = GLYPH_V;
         default: g = GLYPH_NONE;
      endcase
      return g;
   endfunction

   // largest table entry not above the amount
   function automatic logic [IDX_W-1:0] select_entry(input logic [AMT_W-1:0] amt);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(ENTRIES - 1);
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (AMT_W'(entry_worth(IDX_W'(k))) <= amt) begin
            idx = IDX_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

[hdl/rnve_ctrl.sv]
// sequencer for the roman numeral vinculum encoder: split, divide and emit phases
// depends on rnve_pkg
module rnve_ctrl
   import rnve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHK_MEGA;
            end
         end
         S_CHK_MEGA: begin
            if (status.mega_big) begin
               state_in = S_DIV;
            end else begin
               state_in = S_CHK_KILO;
            end
         end
         S_CHK_KILO: begin
            if (status.kilo_big) begin
               state_in = S_DIV;
            end else if (!status.rem_zero) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free && status.glyph_cap) begin
               state_in = S_IDLE;
            end else if (status.out_free && status.part_done) begin
               state_in = S_CHK_KILO;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         S_CHK_MEGA: begin
            cmd.start_mega = status.mega_big;
         end
         S_CHK_KILO: begin
            cmd.start_kilo = status.kilo_big;
            cmd.load_plain = !status.kilo_big && !status.rem_zero;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hdl/rnve_dpath.sv]
// datapath: remainder, reciprocal divider, greedy glyph selector and output register
// depends on rnve_pkg
module rnve_dpath
   import rnve_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [VALUE_W-1:0]  req_value,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [GLYPH_W-1:0]  rsp_glyph,
   output logic [BARS_W-1:0]   rsp_bars,
   output logic                rsp_last
);

   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VALUE_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [BARS_W-1:0]  bars_ff, bars_in;
   logic [GCNT_W-1:0]  glyph_cnt_ff, glyph_cnt_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [GLYPH_W-1:0] pend_glyph_ff, pend_glyph_in;
   logic               out_valid_ff, out_valid_in;
   logic [GLYPH_W-1:0] out_glyph_ff, out_glyph_in;
   logic [BARS_W-1:0]  out_bars_ff, out_bars_in;
   logic               out_last_ff, out_last_in;

   logic                 is_mega;
   logic [MUL_A_W-1:0]   mul_a;
   logic [RECIP_W-1:0]   mul_b;
   logic [DIVISOR_W-1:0] divisor;
   logic [AMT_W-1:0]     quot;
   logic [IDX_W-1:0]     sel;
   logic [AMT_W-1:0]     worth;
   logic                 is_pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      prod_ff <= prod_in;
      back_ff <= back_in;
      cnt_ff <= cnt_in;
      amt_ff <= amt_in;
      bars_ff <= bars_in;
      glyph_cnt_ff <= glyph_cnt_in;
      pend_glyph_ff <= pend_glyph_in;
      out_glyph_ff <= out_glyph_in;
      out_bars_ff <= out_bars_in;
      out_last_ff <= out_last_in;
   end

   // millions: (rem >> 6) / 15625, thousands: (rem >> 3) / 125
   assign is_mega = bars_ff == BARS_MEGA;
   assign mul_a = is_mega ? rem_ff[VALUE_W-1:6] : {7'd0, rem_ff[21:3]};
   assign mul_b = is_mega ? RECIP_MEGA : RECIP_KILO;
   assign divisor = is_mega ? DIVISOR_MEGA : DIVISOR_KILO;
   assign quot = is_mega ? prod_ff[52:40] : {1'b0, prod_ff[37:26]};

   assign sel = select_entry(amt_ff);
   assign worth = AMT_W'(entry_worth(sel));
   assign is_pair = entry_second(sel) != GLYPH_NONE;

   always_comb begin
      status.mega_big = rem_ff >= LIMIT_MEGA;
      status.kilo_big = rem_ff >= LIMIT_KILO;
      status.rem_zero = rem_ff == '0;
      status.div_last = cnt_ff == DIV_PH_SUB;
      status.out_free = !out_valid_ff || rsp_tready;
      status.glyph_cap = glyph_cnt_ff == GLYPH_LAST_IDX;
      if (pend_valid_ff) begin
         status.part_done = amt_ff == '0;
      end else begin
         status.part_done = !is_pair && (amt_ff == worth);
      end
   end

   always_comb begin
      rem_in = rem_ff;
      prod_in = prod_ff;
      back_in = back_ff;
      cnt_in = cnt_ff;
      amt_in = amt_ff;
      bars_in = bars_ff;
      glyph_cnt_in = glyph_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_glyph_in = pend_glyph_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_glyph_in = out_glyph_ff;
      out_bars_in = out_bars_ff;
      out_last_in = out_last_ff;

      if (cmd.load) begin
         rem_in = req_value;
         pend_valid_in = 1'b0;
         glyph_cnt_in = '0;
      end
      if (cmd.start_mega) begin
         cnt_in = DIV_PH_MUL;
         bars_in = BARS_MEGA;
      end
      if (cmd.start_kilo) begin
         cnt_in = DIV_PH_MUL;
         bars_in = BARS_KILO;
      end
      if (cmd.load_plain) begin
         amt_in = rem_ff[AMT_W-1:0];
         rem_in = '0;
         bars_in = BARS_NONE;
      end
      if (cmd.div_step) begin
         case (cnt_ff)
            DIV_PH_MUL: begin
               prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            DIV_PH_BACK: begin
               amt_in = quot;
               back_in = VALUE_W'(quot) * VALUE_W'(divisor);
            end
            DIV_PH_SUB: begin
               rem_in = rem_ff - back_ff;
            end
            default: begin
               rem_in = rem_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_bars_in = bars_ff;
         out_last_in = (status.part_done && status.rem_zero) || status.glyph_cap;
         glyph_cnt_in = glyph_cnt_ff + 1'b1;
         if (pend_valid_ff) begin
            out_glyph_in = pend_glyph_ff;
            pend_valid_in = 1'b0;
         end else begin
            out_glyph_in = entry_first(sel);
            amt_in = amt_ff - worth;
            pend_valid_in = is_pair;
            pend_glyph_in = entry_second(sel);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_glyph = out_glyph_ff;
   assign rsp_bars = out_bars_ff;
   assign rsp_last = out_last_ff;

endmodule

[hdl/roman_numeral_vinculum_encoder_core.sv]
// top level of the roman numeral vinculum encoder
// depends on rnve_pkg, rnve_ctrl and rnve_dpath
//
// Takes one 32-bit unsigned word and returns its Roman numeral as a run of
// glyph words, one glyph per word, with rsp_tlast on the final glyph; zero
// gives no words. Amounts of four million and up carry the millions with
// double bars, a remainder of four thousand and up carries the thousands with
// single bars, the rest is plain. A numeral longer than 39 glyphs is cut after
// the 39th, which then carries rsp_tlast. One word is handled at a time: a new
// word is taken once the previous one has been fully split and emitted. The
// millions and thousands are each found by a reciprocal multiply, a multiply
// back and a subtract, and the glyph stage emits one glyph per cycle while the
// result side is ready. The last glyph sits in the output register and may be
// taken after the next word has been accepted.
module roman_numeral_vinculum_encoder_core
   import rnve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // glyph[2:0], bars[4:3], zero[7:5]
   output logic        rsp_tlast
);

   cmd_type            cmd;
   status_type         status;
   logic [GLYPH_W-1:0] rsp_glyph;
   logic [BARS_W-1:0]  rsp_bars;

   rnve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rnve_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_glyph  (rsp_glyph),
      .rsp_bars   (rsp_bars),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_bars, rsp_glyph};

endmodule

[hdl/rnve_checker.sv]
// port-level checks for roman_numeral_vinculum_encoder_core, bound to the top level
// depends on rnve_pkg
module rnve_checker
   import rnve_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // only real letters and bar counts
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != GLYPH_NONE && rsp_tdata[4:3] != BARS_BAD)
      else $error("bad glyph or bar code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000)
      else $error("padding bits set");

   // one word in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // zero word never produces a glyph in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata == 32'd0 && !rsp_tvalid |=> !rsp_tvalid)
      else $error("glyph for zero word");

endmodule

bind roman_numeral_vinculum_encoder_core rnve_checker u_rnve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[bench/rnve_checker.sv]
// glyph stream checker for the roman numeral vinculum encoder
// predicts the numeral of every accepted value and compares each glyph word
// depends on rnve_pkg
`timescale 1ns / 100ps

module rnve_scoreboard
   import rnve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          glyphs_pending
);

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [BARS_W-1:0]  bars;
      logic               last;
   } glyph_word_type;

   glyph_word_type expected_glyphs[$];

   int unsigned numeral_worth [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
   logic [GLYPH_W-1:0] numeral_head [13] = '{GLYPH_M, GLYPH_C, GLYPH_D, GLYPH_C, GLYPH_C,
      GLYPH_X, GLYPH_L, GLYPH_X, GLYPH_X, GLYPH_I, GLYPH_V, GLYPH_I, GLYPH_I};
   logic [GLYPH_W-1:0] numeral_tail [13] = '{GLYPH_NONE, GLYPH_M, GLYPH_NONE, GLYPH_D,
      GLYPH_NONE, GLYPH_C, GLYPH_NONE, GLYPH_L, GLYPH_NONE, GLYPH_X, GLYPH_NONE, GLYPH_V,
      GLYPH_NONE};

   task automatic add_glyph(input logic [GLYPH_W-1:0] glyph, input logic [BARS_W-1:0] bars);
      glyph_word_type word;
      word.glyph = glyph;
      word.bars = bars;
      word.last = 1'b0;
      expected_glyphs.insert(expected_glyphs.size(), word);
   endtask

   // greedy subtractive spelling of one part
   task automatic spell_part(input int unsigned amount, input logic [BARS_W-1:0] bars);
      int unsigned left;
      left = amount;
      for (int k = 0; k < 13; k++) begin
         while (left >= numeral_worth[k]) begin
            add_glyph(numeral_head[k], bars);
            if (numeral_tail[k] != GLYPH_NONE) begin
               add_glyph(numeral_tail[k], bars);
            end
            left = left - numeral_worth[k];
         end
      end
   endtask

   task automatic predict_numeral(input logic [31:0] value);
      int unsigned    rest;
      int             start_size;
      glyph_word_type final_word;
      rest = value;
      start_size = expected_glyphs.size();
      if (rest >= LIMIT_MEGA) begin
         spell_part(rest / 1000000, BARS_MEGA);
         rest = rest % 1000000;
      end
      if (rest >= LIMIT_KILO) begin
         spell_part(rest / 1000, BARS_KILO);
         rest = rest % 1000;
      end
      if (rest > 0) begin
         spell_part(rest, BARS_NONE);
      end
      // numeral is cut after the longest allowed run
      while (expected_glyphs.size() > start_size + MAX_GLYPHS) begin
         final_word = expected_glyphs.pop_back();
      end
      if (expected_glyphs.size() > start_size) begin
         final_word = expected_glyphs.pop_back();
         final_word.last = 1'b1;
         expected_glyphs.insert(expected_glyphs.size(), final_word);
      end
   endtask

   task automatic check_glyph_word;
      glyph_word_type want;
      glyph_word_type got;
      got = {rsp_tdata[2:0], rsp_tdata[4:3], rsp_tlast};
      if (expected_glyphs.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("%0t: unexpected glyph word %h tlast %b", $realtime, rsp_tdata, rsp_tlast);
         end
         mismatch_count++;
      end else begin
         want = expected_glyphs.pop_front();
         if (got != want || rsp_tdata[7:5] != 3'd0) begin
            if (mismatch_count < 10) begin
               $display("%0t: glyph mismatch, expected glyph %0d bars %0d last %b,",
                  $realtime, want.glyph, want.bars, want.last);
               $display("   got glyph %0d bars %0d last %b pad %0d",
                  got.glyph, got.bars, got.last, rsp_tdata[7:5]);
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_glyphs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_glyph_word();
         end
         if (req_tvalid && req_tready) begin
            predict_numeral(req_tdata);
         end
      end
      glyphs_pending = expected_glyphs.size();
   end

endmodule

[bench/tb_roman_numeral_vinculum_encoder_core.sv]
// testbench top for the roman numeral vinculum encoder core
// drives values with random gaps and output stalls, verdict from rnve_scoreboard
// depends on rnve_pkg, roman_numeral_vinculum_encoder_core and rnve_scoreboard
`timescale 1ns / 100ps

module tb_roman_numeral_vinculum_encoder_core;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   int  mismatch_count;
   int  glyphs_pending;
   bit  gaps_on = 1'b1;
   bit  stalls_on = 1'b1;
   int  stall_left = 0;

   logic [31:0] corner_values [25] = '{32'd0, 32'd1, 32'd4, 32'd9, 32'd14, 32'd40, 32'd49,
      32'd90, 32'd99, 32'd400, 32'd444, 32'd900, 32'd999, 32'd1000, 32'd3888, 32'd3999,
      32'd4000, 32'd3999999, 32'd4000000, 32'd4003999, 32'd3888888888, 32'hFFFFFFFF,
      32'hAAAAAAAA, 32'h55555555, 32'h80000000};

   roman_numeral_vinculum_encoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rnve_scoreboard numeral_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .glyphs_pending (glyphs_pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // result side stalls in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_value(input logic [31:0] value);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tdata <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] value;
      case ($urandom_range(0, 5))
         0: value = $urandom;
         1: value = $urandom_range(1, 3999);
         2: value = $urandom_range(4000, 3999999);
         3: value = $urandom_range(4000000, 32'hFFFFFFFF);
         4: value = $urandom_range(4, 4293) * 1000000 + $urandom_range(0, 3999);
         default: value = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 99);
      endcase
      return value;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
      end
      for (int i = 0; i < 250; i++) begin
         if (i == 100) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (glyphs_pending != 0) @(negedge clock);
         end
         if (i == 210) begin
            gaps_on = 1'b0;
            stalls_on = 1'b0;
         end
         send_value(random_value());
      end
      req_tvalid <= 1'b0;
      while (glyphs_pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatch_count == 0 && glyphs_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
